// ----- rtl/s2a_pkg.sv -----
// Shared types, constants and the digit glyph function for the
// signed integer to radix ASCII formatter. No dependencies.
`default_nettype none

package s2a_pkg;

    localparam int DIGIT_BITS     = 6;
    localparam int CHAR_BITS      = 8;
    localparam int BITS_PER_CYCLE = 8;

    localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h41;

    typedef struct packed {
        logic neg;
        logic zero;
    } s2a_class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_RD,
        S_WAIT,
        S_ZERO
    } s2a_state_t;

    // Map one digit to its upper-case ASCII glyph; out-of-range codes give '0'.
    function automatic logic [CHAR_BITS-1:0] glyph_for(input logic [DIGIT_BITS-1:0] digit);
        logic [CHAR_BITS-1:0] g;
        if (digit < DIGIT_TEN)
        begin
            g = CHAR_ZERO + {2'b00, digit};
        end
        else if (digit < RADIX_MAX)
        begin
            g = CHAR_A + {2'b00, digit - DIGIT_TEN};
        end
        else
        begin
            g = CHAR_ZERO;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/s2a_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module s2a_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/s2a_front.sv -----
// Front end: accepts input beats, classifies sign and zero, takes the
// magnitude, and holds the result in a two-entry queue. Uses s2a_pkg.
`default_nettype none

module s2a_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [VALUE_WIDTH-1:0]  value,
    output logic                         q_valid,
    input  wire logic                    q_pop,
    output s2a_pkg::s2a_class_t          q_class,
    output logic      [VALUE_WIDTH-1:0]  q_mag
);
    import s2a_pkg::*;

    logic [VALUE_WIDTH-1:0] mag_c;
    s2a_class_t             class_c;
    logic                   push;

    logic [VALUE_WIDTH-1:0] mag_reg   [2];
    s2a_class_t             class_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             fill_reg,   fill_next;

    always_comb
    begin
        class_c.neg  = value[VALUE_WIDTH-1];
        class_c.zero = (value == '0);
        mag_c        = class_c.neg ? (~value + VALUE_WIDTH'(1)) : value;
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_class  = class_reg[rd_ptr_reg];
    assign q_mag    = mag_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mag_reg[wr_ptr_reg]   <= mag_c;
            class_reg[wr_ptr_reg] <= class_c;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/s2a_back.sv -----
// Back end: divides the magnitude by the radix, eight quotient bits per
// cycle, stores digits in s2a_ram, then emits them most significant
// first through an output register. Uses s2a_pkg and s2a_ram.
`default_nettype none

module s2a_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [s2a_pkg::DIGIT_BITS-1:0]    radix_cur,
    input  wire logic                              q_valid,
    output logic                                   q_pop,
    input  wire s2a_pkg::s2a_class_t               q_class,
    input  wire logic [VALUE_WIDTH-1:0]            q_mag,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [s2a_pkg::CHAR_BITS-1:0]     char_code,
    output logic                                   last_char
);
    import s2a_pkg::*;

    localparam int STEPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PW    = STEPS * BITS_PER_CYCLE;
    localparam int SW    = $clog2(STEPS + 1);
    localparam int CW    = $clog2(VALUE_WIDTH + 1);
    localparam int AW    = $clog2(VALUE_WIDTH);

    s2a_state_t state_reg, state_next;

    logic [PW-1:0]         div_reg,  div_next;
    logic [DIGIT_BITS-1:0] rem_reg,  rem_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  neg_reg,  neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]  char_reg, char_next;
    logic                  last_reg, last_next;

    logic [PW-1:0]         div_c;
    logic [DIGIT_BITS-1:0] rem_c;
    logic [DIGIT_BITS:0]   trial;
    logic                  ge;
    logic                  div_done;
    logic                  out_free;
    logic                  wr_en;
    logic                  rd_en;
    logic [DIGIT_BITS-1:0] rd_data;

    // Eight restoring-division steps on the narrow remainder.
    always_comb
    begin
        div_c = div_reg;
        rem_c = rem_reg;
        trial = '0;
        ge    = 1'b0;
        for (int j = 0; j < BITS_PER_CYCLE; j++)
        begin
            trial = {rem_c, div_c[PW-1]};
            ge    = (trial >= {1'b0, radix_cur});
            if (ge)
            begin
                trial = trial - {1'b0, radix_cur};
            end
            rem_c = trial[DIGIT_BITS-1:0];
            div_c = {div_c[PW-2:0], ge};
        end
    end

    assign div_done = (step_reg == SW'(STEPS - 1));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_class.zero ? S_ZERO : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done && (div_c == '0))
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (!neg_reg || out_free)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = (count_reg == CW'(1)) ? S_IDLE : S_RD;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    div_next   = PW'(q_mag);
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    neg_next   = q_class.neg;
                end
            end
            S_DIV:
            begin
                div_next = div_c;
                if (div_done)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    rem_next   = '0;
                    step_next  = '0;
                end
                else
                begin
                    rem_next  = rem_c;
                    step_next = step_reg + SW'(1);
                end
            end
            S_SIGN:
            begin
                if (neg_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                end
            end
            S_RD:
            begin
                rd_en = 1'b1;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = glyph_for(rd_data);
                    last_next      = (count_reg == CW'(1));
                    count_next     = count_reg - CW'(1);
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    s2a_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rem_c),
        .rd_en   (rd_en),
        .rd_addr (AW'(count_reg - CW'(1))),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_radix_ascii.sv -----
// Top level of the signed integer to radix ASCII formatter: radix
// register, front end with queue, divide-and-emit back end.
// Depends on s2a_pkg, s2a_front, s2a_back (and s2a_ram below it).
//
//  channel  | signals                               | flow
//  ---------+---------------------------------------+-------------------
//  input    | in_valid, in_stall, value             | one value per beat
//  output   | out_valid, out_stall, char_code,      | one char per beat
//           | last_char                             |
//  config   | radix_valid, radix_ready, radix       | one write per beat
//
// Sequence: the shared divider makes one full pass over the magnitude per
// digit, then the digits are read back from the RAM and emitted after the
// sign, most significant first; zero goes straight to a single '0' character.
// Reset: rst_n clears the queue, sequencer and output register; radix 10.
// Stalls: out_stall holds the output register; in_stall rises only when
// the two-entry queue is full, so the front keeps taking values meanwhile.
`default_nettype none

module signed_int_to_radix_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]        value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic             [s2a_pkg::CHAR_BITS-1:0] char_code,
    output logic                                      last_char,
    input  wire logic                                 radix_valid,
    output logic                                      radix_ready,
    input  wire logic        [s2a_pkg::DIGIT_BITS-1:0] radix
);
    import s2a_pkg::*;

    logic [DIGIT_BITS-1:0]  radix_reg, radix_next;
    logic                   q_valid;
    logic                   q_pop;
    s2a_class_t             q_class;
    logic [VALUE_WIDTH-1:0] q_mag;

    // Always take config beats; drop writes outside 2..36.
    assign radix_ready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (radix_valid && (radix >= RADIX_MIN) && (radix <= RADIX_MAX))
        begin
            radix_next = radix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Classify and queue incoming values.
    s2a_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_class  (q_class),
        .q_mag    (q_mag)
    );

    // Divide, store digits, emit characters.
    s2a_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix_cur (radix_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_class   (q_class),
        .q_mag     (q_mag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

`default_nettype wire

// ----- tb/tb_signed_int_to_radix_ascii.sv -----
// Testbench for signed_int_to_radix_ascii: drives values and radix writes,
// predicts the character beats in a scoreboard class and checks each one.
// Depends on s2a_pkg and the RTL of the formatter.

module tb_signed_int_to_radix_ascii;

    import s2a_pkg::*;

    localparam int VW          = 32;
    localparam int PHASE_ITEMS = 18;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } text_char_t;

    // Scoreboard: turns each accepted value into its expected text and
    // matches character beats against it, oldest first.
    class radix_text_board;
        text_char_t            pending_chars[$];
        logic [DIGIT_BITS-1:0] base;
        int                    errors;

        function new();
            base   = RADIX_RESET;
            errors = 0;
        endfunction

        function void set_radix(logic [DIGIT_BITS-1:0] r);
            if (r >= RADIX_MIN && r <= RADIX_MAX)
            begin
                base = r;
            end
        endfunction

        function logic [CHAR_BITS-1:0] digit_char(logic [DIGIT_BITS-1:0] d);
            if (d < DIGIT_TEN)
            begin
                return CHAR_ZERO + {2'b00, d};
            end
            return CHAR_A + {2'b00, d - DIGIT_TEN};
        endfunction

        function void push_char(logic [CHAR_BITS-1:0] code, logic last);
            text_char_t c;
            c.code = code;
            c.last = last;
            pending_chars.push_back(c);
        endfunction

        // Expand one value into sign, then digits most significant first.
        function void add_value(logic [VW-1:0] v);
            s2a_class_t            kind;
            logic [VW-1:0]         left;
            logic [DIGIT_BITS-1:0] digits[$];
            kind.neg  = v[VW-1];
            left      = kind.neg ? (~v + 1'b1) : v;
            kind.zero = (left == '0);
            if (kind.zero)
            begin
                push_char(CHAR_ZERO, 1'b1);
            end
            else
            begin
                while (left != '0)
                begin
                    digits.push_back(DIGIT_BITS'(left % VW'(base)));
                    left = left / VW'(base);
                end
                if (kind.neg)
                begin
                    push_char(CHAR_MINUS, 1'b0);
                end
                for (int k = digits.size() - 1; k >= 0; k--)
                begin
                    push_char(digit_char(digits[k]), k == 0);
                end
            end
        endfunction

        function void check_char(logic [CHAR_BITS-1:0] code, logic last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char beat: expected none, got code %h last %b",
                         $time, code, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: char_code mismatch: expected %h, got %h",
                         $time, want.code, code);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_char mismatch: expected %b, got %b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [VW-1:0]  value;
    logic                  out_valid;
    logic                  out_stall;
    logic [CHAR_BITS-1:0]  char_code;
    logic                  last_char;
    logic                  radix_valid;
    logic                  radix_ready;
    logic [DIGIT_BITS-1:0] radix;

    radix_text_board board;

    // Control flags shared with the stall process.
    bit quiet_tail;
    bit long_hold;

    signed_int_to_radix_ascii #(
        .VALUE_WIDTH(VW)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .radix_valid(radix_valid),
        .radix_ready(radix_ready),
        .radix      (radix)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Check every accepted output beat; values sampled here are the ones
    // that stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_char(char_code, last_char);
        end
    end

    // Receiver: stall at random (one run in three) over runs of random length, hold off for a
    // long stretch once on request, and stop stalling in the tail.
    initial
    begin
        int run;
        forever
        begin
            if (quiet_tail)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 15);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (run) @(posedge clk);
            end
        end
    end

    // Offer one value and hold it until the beat is taken; optionally
    // drop valid for a random gap afterwards.
    task automatic send_value(input logic [VW-1:0] v, input bit allow_gaps);
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
        board.add_value(v);
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected character has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the radix register; out-of-range data must be ignored.
    task automatic write_radix(input logic [DIGIT_BITS-1:0] r);
        radix_valid <= 1'b1;
        radix       <= r;
        do @(posedge clk); while (!radix_ready);
        board.set_radix(r);
        radix_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mix of full-range words, small values, extremes and values around
    // powers of the current radix, where the digit count changes.
    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] p;
        int            steps;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return VW'($urandom_range(0, 200)) - VW'(100);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return '0;
                    default: return '1;
                endcase
            end
            4:
            begin
                p     = 1;
                steps = $urandom_range(1, 30);
                for (int i = 0; i < steps; i++)
                begin
                    if (p <= 32'h3FFF_FFFF / VW'(board.base))
                    begin
                        p = p * VW'(board.base);
                    end
                end
                case ($urandom_range(0, 2))
                    0: return p - 1;
                    1: return p;
                    default: return ~p + 1'b1;
                endcase
            end
            default:
            begin
                p = $urandom >> $urandom_range(0, 31);
                return $urandom_range(0, 1) ? p : ~p + 1'b1;
            end
        endcase
    endfunction

    initial
    begin
        logic [DIGIT_BITS-1:0] phase_radix[8];
        board       = new();
        quiet_tail  = 1'b0;
        long_hold   = 1'b0;
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        value       <= '0;
        radix_valid <= 1'b0;
        radix       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset radix of ten: zero, unit values,
        // the extremes and the most negative value.
        send_value(32'd0, 1'b1);
        send_value(32'd1, 1'b1);
        send_value(-32'sd1, 1'b1);
        send_value(32'd9, 1'b1);
        send_value(-32'sd9, 1'b1);
        send_value(32'd10, 1'b1);
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'h8000_0000, 1'b1);
        send_value(32'h8000_0001, 1'b1);
        send_value(32'd1_000_000_000, 1'b1);
        drain();

        // Highest radix: single letter digit and its carry into two digits.
        write_radix(RADIX_MAX);
        send_value(32'd35, 1'b1);
        send_value(32'd36, 1'b1);
        send_value(-32'sd1295, 1'b1);
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'h8000_0000, 1'b1);
        drain();

        // Out-of-range writes must leave radix 36 in place.
        write_radix(6'd0);
        write_radix(6'd1);
        write_radix(6'd37);
        write_radix(6'd63);
        send_value(32'd35, 1'b1);
        drain();

        // Lowest radix: the longest texts, 33 beats for the most negative.
        write_radix(RADIX_MIN);
        send_value(32'h8000_0000, 1'b1);
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'd5, 1'b1);
        send_value(32'd0, 1'b1);
        drain();

        // Random part: one radix per phase, extremes included.
        phase_radix[0] = RADIX_MIN;
        phase_radix[1] = RADIX_MAX;
        phase_radix[2] = 6'($urandom_range(2, 36));
        phase_radix[3] = 6'd16;
        phase_radix[4] = 6'($urandom_range(2, 36));
        phase_radix[5] = 6'd8;
        phase_radix[6] = 6'($urandom_range(2, 36));
        phase_radix[7] = RADIX_RESET;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_radix(phase_radix[ph]);
            if ($urandom_range(0, 1) == 0)
            begin
                write_radix($urandom_range(0, 1) ? 6'($urandom_range(0, 1))
                                                 : 6'($urandom_range(37, 63)));
            end
            // Hold the receiver off while values keep coming so the input
            // queue fills and in_stall rises.
            if (ph == 2)
            begin
                long_hold = 1'b1;
            end
            // Last phase runs with no idling on either side.
            if (ph == 7)
            begin
                quiet_tail = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_value(pick_value(), ph != 2 && ph != 7);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d characters outstanding", $time, board.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/s2a_pkg.sv
rtl/s2a_ram.sv
rtl/s2a_front.sv
rtl/s2a_back.sv
rtl/signed_int_to_radix_ascii.sv
tb/tb_signed_int_to_radix_ascii.sv
